// ===== hw/rtl/ippe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ippe_pkg
// Shared constants and types of the in-place pivot partition engine.
// ---------------------------------------------------------------------------
package ippe_pkg;

    localparam int VALUE_W      = 64;
    localparam int ROW_ID_W     = 32;
    localparam int CAPACITY_DEF = 64;
    localparam int COUNT_W_DEF  = $clog2(CAPACITY_DEF + 1);

    localparam logic signed [VALUE_W-1:0] PIVOT_RESET = 64'sd5000;

    // One stored column entry: value and the row id that travels with it.
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [ROW_ID_W-1:0]       row_id;
    } entry_t;

endpackage
`default_nettype wire

// ===== hw/rtl/ippe_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ippe_if
// Valid/ready channels of the partition engine: input items, result items
// and the pivot configuration write.
// ---------------------------------------------------------------------------
interface ippe_item_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [ippe_pkg::VALUE_W-1:0]    element_value;
    logic [ippe_pkg::ROW_ID_W-1:0]          row_id;
    logic                                   last_element;

    modport source (output valid, element_value, row_id, last_element, input ready);
    modport sink   (input valid, element_value, row_id, last_element, output ready);
endinterface

interface ippe_result_if #(
    parameter int COUNT_W = ippe_pkg::COUNT_W_DEF
);
    logic                                   valid;
    logic                                   ready;
    logic signed [ippe_pkg::VALUE_W-1:0]    out_value;
    logic [ippe_pkg::ROW_ID_W-1:0]          out_row_id;
    logic [COUNT_W-1:0]                     split_position;
    logic                                   last_result;

    modport source (output valid, out_value, out_row_id, split_position, last_result,
                    input ready);
    modport sink   (input valid, out_value, out_row_id, split_position, last_result,
                    output ready);
endinterface

interface ippe_cfg_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [ippe_pkg::VALUE_W-1:0]    pivot_value;

    modport source (output valid, pivot_value, input ready);
    modport sink   (input valid, pivot_value, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/ippe_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ippe_store
// Column memory: one write port, two read ports with registered read data.
// ---------------------------------------------------------------------------
module ippe_store #(
    parameter int  CAPACITY  = ippe_pkg::CAPACITY_DEF,
    parameter type mem_req_t = logic
) (
    input  wire logic             clk,
    input  wire mem_req_t         mem_req,
    output ippe_pkg::entry_t      rd_a,
    output ippe_pkg::entry_t      rd_b
);

    ippe_pkg::entry_t mem [CAPACITY];

    // Read data holds while its port is not enabled.
    always_ff @(posedge clk)
    begin
        if (mem_req.we)
        begin
            mem[mem_req.waddr] <= mem_req.wdata;
        end
        if (mem_req.re_a)
        begin
            rd_a <= mem[mem_req.raddr_a];
        end
        if (mem_req.re_b)
        begin
            rd_b <= mem[mem_req.raddr_b];
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/ippe_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ippe_seq
// Sequencer: load the column, run the partition scan over the memory,
// then stream the stored entries out through an output register.
// ---------------------------------------------------------------------------
module ippe_seq #(
    parameter int  CAPACITY  = ippe_pkg::CAPACITY_DEF,
    parameter type mem_req_t = logic
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic signed [ippe_pkg::VALUE_W-1:0]  pivot,
    ippe_item_if.sink                                 item,
    ippe_result_if.source                             result,
    output mem_req_t                                  mem_req,
    input  wire ippe_pkg::entry_t                     rd_a,
    input  wire ippe_pkg::entry_t                     rd_b
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_LOAD,
        S_P_READ,
        S_P_EVAL,
        S_SWAP,
        S_E_READ,
        S_E_WAIT
    } state_t;

    state_t             state_reg;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      lo_reg;
    logic [AW-1:0]      hi_reg;
    logic [AW-1:0]      k_reg;
    ippe_pkg::entry_t   hold_reg;

    logic               out_valid_reg;
    ippe_pkg::entry_t   out_entry_reg;
    logic [CW-1:0]      out_split_reg;
    logic               out_last_reg;

    logic               in_take;
    logic               has_room;
    logic [CW-1:0]      count_next;
    ippe_pkg::entry_t   in_entry;
    logic               lo_less;
    logic               hi_less;
    logic               meet;
    logic               both_wrong;
    logic [CW-1:0]      lo_next;
    logic [AW-1:0]      hi_next;
    logic               out_free;
    logic               out_load;
    logic               emit_last;

    assign item.ready = (state_reg == S_LOAD);
    assign in_take    = item.valid && item.ready;
    assign has_room   = (count_reg < CW'(CAPACITY));
    assign count_next = count_reg + CW'(has_room);
    assign in_entry   = '{value: item.element_value, row_id: item.row_id};

    assign lo_less    = ($signed(rd_a.value) < pivot);
    assign hi_less    = ($signed(rd_b.value) < pivot);
    assign meet       = (lo_reg == CW'(hi_reg));
    assign both_wrong = !lo_less && hi_less;

    // Pointer moves of a scan step without a swap.
    assign lo_next    = lo_reg + CW'(lo_less);
    assign hi_next    = hi_reg - AW'(!hi_less);

    assign out_free   = !out_valid_reg || result.ready;
    assign out_load   = (state_reg == S_E_WAIT) && out_free;
    assign emit_last  = ((CW'(k_reg) + CW'(1)) == count_reg);

    always_comb
    begin
        mem_req         = '0;
        mem_req.raddr_a = lo_reg[AW-1:0];
        mem_req.raddr_b = hi_reg;
        mem_req.waddr   = count_reg[AW-1:0];
        mem_req.wdata   = in_entry;
        unique case (state_reg)
            S_LOAD:
            begin
                mem_req.we = in_take && has_room;
            end
            S_P_READ:
            begin
                mem_req.re_a = 1'b1;
                mem_req.re_b = 1'b1;
            end
            S_P_EVAL:
            begin
                // Front half of a swap: the back entry moves to the front.
                mem_req.we    = !meet && both_wrong;
                mem_req.waddr = lo_reg[AW-1:0];
                mem_req.wdata = rd_b;
            end
            S_SWAP:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = hi_reg;
                mem_req.wdata = hold_reg;
            end
            S_E_READ:
            begin
                mem_req.re_a    = 1'b1;
                mem_req.raddr_a = k_reg;
            end
            S_E_WAIT:
            begin
                mem_req.re_a = 1'b0;
            end
            default:
            begin
                mem_req.we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            count_reg     <= '0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (result.valid && result.ready && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_LOAD:
                begin
                    if (in_take)
                    begin
                        count_reg <= count_next;
                        if (item.last_element)
                        begin
                            lo_reg    <= '0;
                            hi_reg    <= AW'(count_next - CW'(1));
                            state_reg <= S_P_READ;
                        end
                    end
                end
                S_P_READ:
                begin
                    state_reg <= S_P_EVAL;
                end
                S_P_EVAL:
                begin
                    if (meet)
                    begin
                        lo_reg    <= lo_next;
                        k_reg     <= '0;
                        state_reg <= S_E_READ;
                    end
                    else if (both_wrong)
                    begin
                        hold_reg  <= rd_a;
                        state_reg <= S_SWAP;
                    end
                    else
                    begin
                        lo_reg <= lo_next;
                        hi_reg <= hi_next;
                        k_reg  <= '0;
                        state_reg <= (lo_next <= CW'(hi_next)) ? S_P_READ : S_E_READ;
                    end
                end
                S_SWAP:
                begin
                    lo_reg    <= lo_reg + CW'(1);
                    hi_reg    <= hi_reg - AW'(1);
                    k_reg     <= '0;
                    state_reg <= ((lo_reg + CW'(1)) <= CW'(hi_reg - AW'(1)))
                                 ? S_P_READ : S_E_READ;
                end
                S_E_READ:
                begin
                    state_reg <= S_E_WAIT;
                end
                S_E_WAIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_entry_reg <= rd_a;
                        out_split_reg <= lo_reg;
                        out_last_reg  <= emit_last;
                        if (emit_last)
                        begin
                            count_reg <= '0;
                            state_reg <= S_LOAD;
                        end
                        else
                        begin
                            k_reg     <= k_reg + AW'(1);
                            state_reg <= S_E_READ;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.out_value      = out_entry_reg.value;
    assign result.out_row_id     = out_entry_reg.row_id;
    assign result.split_position = out_split_reg;
    assign result.last_result    = out_last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("column count beyond capacity");

    a_eval_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_P_EVAL |-> lo_reg <= CW'(hi_reg))
        else $error("scan step with crossed pointers");

    a_split_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_E_READ |-> lo_reg <= count_reg)
        else $error("split position beyond column length");

    a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.we |-> (state_reg == S_LOAD || state_reg == S_P_EVAL
                        || state_reg == S_SWAP))
        else $error("memory write outside load or swap");

    a_column_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_E_WAIT && out_free && emit_last)
        |=> (count_reg == '0 && state_reg == S_LOAD))
        else $error("column not released after final result");

endmodule
`default_nettype wire

// ===== hw/rtl/inplace_pivot_partition_engine_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// inplace_pivot_partition_engine_top
// Loads a column of signed values with row ids, partitions it in place
// around the pivot, and streams the column back with the split position.
// ---------------------------------------------------------------------------
// Usage: send the column one item at a time on item; the item with
// last_element set closes the column (items beyond CAPACITY are dropped,
// the closing item still starts the partition). While the column loads,
// item.ready stays high. The scan then works on a single-write, dual-read
// memory with registered read data: a step without a swap reads both
// pointers and then evaluates, a step with a swap adds a separate state
// for the second write, and the scan takes at most about n steps for a
// column of n entries. The column is then read back entry by entry: each
// entry is read from the memory, then registered into the output register
// once that register is free, so the read-back waits on result.ready.
// While the column is being partitioned or emitted no new item is taken;
// the next column can start loading as soon as the last result sits in the
// output register. Every result carries split_position, the count of
// entries below the pivot. Write the pivot on cfg only while the block is
// idle; it resets to 5000 and is compared as a signed number.
// ---------------------------------------------------------------------------
module inplace_pivot_partition_engine_top #(
    parameter int CAPACITY = ippe_pkg::CAPACITY_DEF
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    ippe_cfg_if.sink       cfg,
    ippe_item_if.sink      item,
    ippe_result_if.source  result
);

    localparam int AW = $clog2(CAPACITY);

    // Memory request from the sequencer to the column store.
    typedef struct packed {
        logic               we;
        logic [AW-1:0]      waddr;
        ippe_pkg::entry_t   wdata;
        logic               re_a;
        logic [AW-1:0]      raddr_a;
        logic               re_b;
        logic [AW-1:0]      raddr_b;
    } mem_req_t;

    logic signed [ippe_pkg::VALUE_W-1:0] pivot_reg;
    mem_req_t                            mem_req;
    ippe_pkg::entry_t                    rd_a;
    ippe_pkg::entry_t                    rd_b;

    // Always take configuration writes; the user must send them only while idle, as the block does not enforce it.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pivot_reg <= ippe_pkg::PIVOT_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            pivot_reg <= cfg.pivot_value;
        end
    end

    // Control: load, partition scan, emit.
    ippe_seq #(
        .CAPACITY  (CAPACITY),
        .mem_req_t (mem_req_t)
    ) u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .pivot   (pivot_reg),
        .item    (item),
        .result  (result),
        .mem_req (mem_req),
        .rd_a    (rd_a),
        .rd_b    (rd_b)
    );

    // Column store: values and row ids side by side.
    ippe_store #(
        .CAPACITY  (CAPACITY),
        .mem_req_t (mem_req_t)
    ) u_store (
        .clk     (clk),
        .mem_req (mem_req),
        .rd_a    (rd_a),
        .rd_b    (rd_b)
    );

endmodule
`default_nettype wire
